>>> rtl/rpis_pkg.sv
package rpis_pkg;

   localparam int COORD_W = 16;
   localparam int INDEX_W = 12;
   localparam int COUNT_W = 13;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_TRIAL = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic REG_POINT_COUNT = 1'b0;
   localparam logic REG_TOLERANCE   = 1'b1;

   // Operand sources of the shared multiplier.
   localparam logic [4:0] SRC_UX  = 5'd0;
   localparam logic [4:0] SRC_UY  = 5'd1;
   localparam logic [4:0] SRC_UZ  = 5'd2;
   localparam logic [4:0] SRC_VX  = 5'd3;
   localparam logic [4:0] SRC_VY  = 5'd4;
   localparam logic [4:0] SRC_VZ  = 5'd5;
   localparam logic [4:0] SRC_P1X = 5'd6;
   localparam logic [4:0] SRC_P1Y = 5'd7;
   localparam logic [4:0] SRC_P1Z = 5'd8;
   localparam logic [4:0] SRC_PX  = 5'd9;
   localparam logic [4:0] SRC_PY  = 5'd10;
   localparam logic [4:0] SRC_PZ  = 5'd11;
   localparam logic [4:0] SRC_A   = 5'd12;
   localparam logic [4:0] SRC_B   = 5'd13;
   localparam logic [4:0] SRC_C   = 5'd14;
   localparam logic [4:0] SRC_D   = 5'd15;
   localparam logic [4:0] SRC_NRM = 5'd16;
   localparam logic [4:0] SRC_VAL = 5'd17;
   localparam logic [4:0] SRC_TOL = 5'd18;
   localparam logic [4:0] SRC_T2  = 5'd19;
   localparam logic [4:0] SRC_ONE = 5'd20;

   // Registers loaded from the accumulator at the end of a micro-op.
   localparam logic [3:0] DST_NONE = 4'd0;
   localparam logic [3:0] DST_A    = 4'd1;
   localparam logic [3:0] DST_B    = 4'd2;
   localparam logic [3:0] DST_C    = 4'd3;
   localparam logic [3:0] DST_D    = 4'd4;
   localparam logic [3:0] DST_NRM  = 4'd5;
   localparam logic [3:0] DST_T2   = 4'd6;
   localparam logic [3:0] DST_LIM  = 4'd7;
   localparam logic [3:0] DST_VAL  = 4'd8;

   localparam logic [1:0] PT_P1  = 2'd0;
   localparam logic [1:0] PT_P2  = 2'd1;
   localparam logic [1:0] PT_P3  = 2'd2;
   localparam logic [1:0] PT_CUR = 2'd3;

   localparam logic [5:0] STEP_SETUP_LAST  = 6'd27;
   localparam logic [5:0] STEP_POINT_FIRST = 6'd28;
   localparam logic [5:0] STEP_POINT_LAST  = 6'd39;

   typedef struct packed {
      logic [1:0]                mode;
      logic [INDEX_W-1:0]        point_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [INDEX_W-1:0]        sample_first;
      logic [INDEX_W-1:0]        sample_second;
      logic [INDEX_W-1:0]        sample_third;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] trial_count;
      logic               became_best;
      logic [COUNT_W-1:0] best_count;
      logic               in_best;
   } rsp_type;

   typedef struct packed {
      logic [4:0] src_a;
      logic [1:0] limb_a;
      logic [4:0] src_b;
      logic [1:0] limb_b;
      logic       neg;
      logic       first;
      logic [3:0] dst;
   } uop_type;

   typedef struct packed {
      logic       mul_en;
      logic       acc_en;
      uop_type    uop;
      logic       pt_en;
      logic [1:0] pt_sel;
   } mac_ctrl_type;

   typedef struct packed {
      logic we0;
      logic we1;
      logic data;
   } bm_wr_type;

   function automatic uop_type mk_uop(logic [4:0] sa, logic [1:0] la, logic [4:0] sb,
                                      logic [1:0] lb, logic ng, logic fi, logic [3:0] ds);
      uop_type u;
      u.src_a  = sa;
      u.limb_a = la;
      u.src_b  = sb;
      u.limb_b = lb;
      u.neg    = ng;
      u.first  = fi;
      u.dst    = ds;
      return u;
   endfunction

   // Micro-program: plane setup first, then the per-point evaluation.
   function automatic uop_type ucode(logic [5:0] step);
      uop_type u;
      unique case (step)
         6'd0:  u = mk_uop(SRC_UY, 2'd0, SRC_VZ, 2'd0, 1'b0, 1'b1, DST_NONE);
         6'd1:  u = mk_uop(SRC_UZ, 2'd0, SRC_VY, 2'd0, 1'b1, 1'b0, DST_A);
         6'd2:  u = mk_uop(SRC_UZ, 2'd0, SRC_VX, 2'd0, 1'b0, 1'b1, DST_NONE);
         6'd3:  u = mk_uop(SRC_UX, 2'd0, SRC_VZ, 2'd0, 1'b1, 1'b0, DST_B);
         6'd4:  u = mk_uop(SRC_UX, 2'd0, SRC_VY, 2'd0, 1'b0, 1'b1, DST_NONE);
         6'd5:  u = mk_uop(SRC_UY, 2'd0, SRC_VX, 2'd0, 1'b1, 1'b0, DST_C);
         6'd6:  u = mk_uop(SRC_A, 2'd0, SRC_P1X, 2'd0, 1'b1, 1'b1, DST_NONE);
         6'd7:  u = mk_uop(SRC_A, 2'd1, SRC_P1X, 2'd0, 1'b1, 1'b0, DST_NONE);
         6'd8:  u = mk_uop(SRC_B, 2'd0, SRC_P1Y, 2'd0, 1'b1, 1'b0, DST_NONE);
         6'd9:  u = mk_uop(SRC_B, 2'd1, SRC_P1Y, 2'd0, 1'b1, 1'b0, DST_NONE);
         6'd10: u = mk_uop(SRC_C, 2'd0, SRC_P1Z, 2'd0, 1'b1, 1'b0, DST_NONE);
         6'd11: u = mk_uop(SRC_C, 2'd1, SRC_P1Z, 2'd0, 1'b1, 1'b0, DST_D);
         6'd12: u = mk_uop(SRC_A, 2'd0, SRC_A, 2'd0, 1'b0, 1'b1, DST_NONE);
         6'd13: u = mk_uop(SRC_A, 2'd0, SRC_A, 2'd1, 1'b0, 1'b0, DST_NONE);
         6'd14: u = mk_uop(SRC_A, 2'd1, SRC_A, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd15: u = mk_uop(SRC_A, 2'd1, SRC_A, 2'd1, 1'b0, 1'b0, DST_NONE);
         6'd16: u = mk_uop(SRC_B, 2'd0, SRC_B, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd17: u = mk_uop(SRC_B, 2'd0, SRC_B, 2'd1, 1'b0, 1'b0, DST_NONE);
         6'd18: u = mk_uop(SRC_B, 2'd1, SRC_B, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd19: u = mk_uop(SRC_B, 2'd1, SRC_B, 2'd1, 1'b0, 1'b0, DST_NONE);
         6'd20: u = mk_uop(SRC_C, 2'd0, SRC_C, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd21: u = mk_uop(SRC_C, 2'd0, SRC_C, 2'd1, 1'b0, 1'b0, DST_NONE);
         6'd22: u = mk_uop(SRC_C, 2'd1, SRC_C, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd23: u = mk_uop(SRC_C, 2'd1, SRC_C, 2'd1, 1'b0, 1'b0, DST_NRM);
         6'd24: u = mk_uop(SRC_TOL, 2'd0, SRC_TOL, 2'd0, 1'b0, 1'b1, DST_T2);
         6'd25: u = mk_uop(SRC_NRM, 2'd0, SRC_T2, 2'd0, 1'b0, 1'b1, DST_NONE);
         6'd26: u = mk_uop(SRC_NRM, 2'd1, SRC_T2, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd27: u = mk_uop(SRC_NRM, 2'd2, SRC_T2, 2'd0, 1'b0, 1'b0, DST_LIM);
         6'd28: u = mk_uop(SRC_D, 2'd0, SRC_ONE, 2'd0, 1'b0, 1'b1, DST_NONE);
         6'd29: u = mk_uop(SRC_D, 2'd1, SRC_ONE, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd30: u = mk_uop(SRC_A, 2'd0, SRC_PX, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd31: u = mk_uop(SRC_A, 2'd1, SRC_PX, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd32: u = mk_uop(SRC_B, 2'd0, SRC_PY, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd33: u = mk_uop(SRC_B, 2'd1, SRC_PY, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd34: u = mk_uop(SRC_C, 2'd0, SRC_PZ, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd35: u = mk_uop(SRC_C, 2'd1, SRC_PZ, 2'd0, 1'b0, 1'b0, DST_VAL);
         6'd36: u = mk_uop(SRC_VAL, 2'd0, SRC_VAL, 2'd0, 1'b0, 1'b1, DST_NONE);
         6'd37: u = mk_uop(SRC_VAL, 2'd0, SRC_VAL, 2'd1, 1'b0, 1'b0, DST_NONE);
         6'd38: u = mk_uop(SRC_VAL, 2'd1, SRC_VAL, 2'd0, 1'b0, 1'b0, DST_NONE);
         6'd39: u = mk_uop(SRC_VAL, 2'd1, SRC_VAL, 2'd1, 1'b0, 1'b0, DST_NONE);
         default: u = mk_uop(SRC_ONE, 2'd3, SRC_ONE, 2'd3, 1'b0, 1'b0, DST_NONE);
      endcase
      return u;
   endfunction

endpackage

>>> rtl/rpis_store.sv
module rpis_store #(
   parameter int MAX_POINTS = 4096,
   parameter int AW = 12
) (
   input  logic                   clock,
   input  logic                   pt_we,
   input  logic [AW-1:0]          pt_waddr,
   input  logic [47:0]            pt_wdata,
   input  rpis_pkg::bm_wr_type    bm_wr,
   input  logic [AW-1:0]          bm_waddr,
   input  logic [AW-1:0]          raddr,
   output logic [47:0]            pt_rdata,
   output logic [1:0]             bm_rdata
);
   import rpis_pkg::*;

   logic [47:0] pt_mem [MAX_POINTS];
   logic        bm0_mem [MAX_POINTS];
   logic        bm1_mem [MAX_POINTS];

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_waddr] <= pt_wdata;
      end
      pt_rdata <= pt_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (bm_wr.we0) begin
         bm0_mem[bm_waddr] <= bm_wr.data;
      end
      bm_rdata[0] <= bm0_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (bm_wr.we1) begin
         bm1_mem[bm_waddr] <= bm_wr.data;
      end
      bm_rdata[1] <= bm1_mem[raddr];
   end

endmodule

>>> rtl/rpis_mac.sv
module rpis_mac (
   input  logic                  clock,
   input  rpis_pkg::mac_ctrl_type ctrl,
   input  logic [47:0]           pt_data,
   input  logic [15:0]           tolerance,
   output logic                  less
);
   import rpis_pkg::*;

   logic signed [15:0]  p1x_ff, p1y_ff, p1z_ff, p1x_in, p1y_in, p1z_in;
   logic signed [15:0]  px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [16:0]  ux_ff, uy_ff, uz_ff, ux_in, uy_in, uz_in;
   logic signed [16:0]  vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic signed [33:0]  a_ff, b_ff, c_ff, a_in, b_in, c_in;
   logic signed [50:0]  d_ff, d_in;
   logic signed [52:0]  val_ff, val_in;
   logic [67:0]         nrm_ff, nrm_in;
   logic [31:0]         t2_ff, t2_in;
   logic [99:0]         lim_ff, lim_in;
   logic signed [111:0] acc_ff, acc_in;
   logic [63:0]         prod_ff, prod_in;
   logic                neg_ff, neg_in, first_ff, first_in;
   logic [2:0]          sh_ff, sh_in;
   logic [3:0]          dst_ff, dst_in;

   logic signed [71:0]  srcv [32];
   logic signed [71:0]  opa, opb;
   logic [71:0]         maga, magb;
   logic [31:0]         limba, limbb;
   logic signed [15:0]  nx, ny, nz;
   logic [111:0]        term;

   assign nx = pt_data[47:32];
   assign ny = pt_data[31:16];
   assign nz = pt_data[15:0];

   always_comb begin
      for (int i = 0; i < 32; i++) begin
         srcv[i] = '0;
      end
      srcv[SRC_UX]  = 72'(ux_ff);
      srcv[SRC_UY]  = 72'(uy_ff);
      srcv[SRC_UZ]  = 72'(uz_ff);
      srcv[SRC_VX]  = 72'(vx_ff);
      srcv[SRC_VY]  = 72'(vy_ff);
      srcv[SRC_VZ]  = 72'(vz_ff);
      srcv[SRC_P1X] = 72'(p1x_ff);
      srcv[SRC_P1Y] = 72'(p1y_ff);
      srcv[SRC_P1Z] = 72'(p1z_ff);
      srcv[SRC_PX]  = 72'(px_ff);
      srcv[SRC_PY]  = 72'(py_ff);
      srcv[SRC_PZ]  = 72'(pz_ff);
      srcv[SRC_A]   = 72'(a_ff);
      srcv[SRC_B]   = 72'(b_ff);
      srcv[SRC_C]   = 72'(c_ff);
      srcv[SRC_D]   = 72'(d_ff);
      srcv[SRC_NRM] = signed'({4'b0, nrm_ff});
      srcv[SRC_VAL] = 72'(val_ff);
      srcv[SRC_TOL] = signed'({56'b0, tolerance});
      srcv[SRC_T2]  = signed'({40'b0, t2_ff});
      srcv[SRC_ONE] = 72'sd1;
   end

   // Operands enter the multiplier as 32-bit limbs of their magnitudes.
   always_comb begin
      opa  = srcv[ctrl.uop.src_a];
      opb  = srcv[ctrl.uop.src_b];
      maga = opa[71] ? 72'(-opa) : 72'(opa);
      magb = opb[71] ? 72'(-opb) : 72'(opb);
      unique case (ctrl.uop.limb_a)
         2'd0:    limba = maga[31:0];
         2'd1:    limba = maga[63:32];
         2'd2:    limba = {24'b0, maga[71:64]};
         default: limba = '0;
      endcase
      unique case (ctrl.uop.limb_b)
         2'd0:    limbb = magb[31:0];
         2'd1:    limbb = magb[63:32];
         2'd2:    limbb = {24'b0, magb[71:64]};
         default: limbb = '0;
      endcase
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      first_in = first_ff;
      sh_in    = sh_ff;
      dst_in   = dst_ff;
      if (ctrl.mul_en) begin
         prod_in  = limba * limbb;
         neg_in   = opa[71] ^ opb[71] ^ ctrl.uop.neg;
         first_in = ctrl.uop.first;
         sh_in    = 3'({1'b0, ctrl.uop.limb_a}) + 3'({1'b0, ctrl.uop.limb_b});
         dst_in   = ctrl.uop.dst;
      end
   end

   always_comb begin
      unique case (sh_ff)
         3'd0:    term = 112'(prod_ff);
         3'd1:    term = 112'(prod_ff) << 32;
         3'd2:    term = 112'(prod_ff) << 64;
         default: term = '0;
      endcase
      acc_in = acc_ff;
      if (ctrl.acc_en) begin
         acc_in = (first_ff ? 112'sd0 : acc_ff)
                + (neg_ff ? -signed'(term) : signed'(term));
      end
      a_in   = a_ff;
      b_in   = b_ff;
      c_in   = c_ff;
      d_in   = d_ff;
      nrm_in = nrm_ff;
      t2_in  = t2_ff;
      lim_in = lim_ff;
      val_in = val_ff;
      if (ctrl.acc_en) begin
         unique case (dst_ff)
            DST_A:   a_in   = acc_in[33:0];
            DST_B:   b_in   = acc_in[33:0];
            DST_C:   c_in   = acc_in[33:0];
            DST_D:   d_in   = acc_in[50:0];
            DST_NRM: nrm_in = acc_in[67:0];
            DST_T2:  t2_in  = acc_in[31:0];
            DST_LIM: lim_in = acc_in[99:0];
            DST_VAL: val_in = acc_in[52:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      p1x_in = p1x_ff;
      p1y_in = p1y_ff;
      p1z_in = p1z_ff;
      px_in  = px_ff;
      py_in  = py_ff;
      pz_in  = pz_ff;
      ux_in  = ux_ff;
      uy_in  = uy_ff;
      uz_in  = uz_ff;
      vx_in  = vx_ff;
      vy_in  = vy_ff;
      vz_in  = vz_ff;
      if (ctrl.pt_en) begin
         unique case (ctrl.pt_sel)
            PT_P1: begin
               p1x_in = nx;
               p1y_in = ny;
               p1z_in = nz;
            end
            PT_P2: begin
               ux_in = 17'(nx) - 17'(p1x_ff);
               uy_in = 17'(ny) - 17'(p1y_ff);
               uz_in = 17'(nz) - 17'(p1z_ff);
            end
            PT_P3: begin
               vx_in = 17'(nx) - 17'(p1x_ff);
               vy_in = 17'(ny) - 17'(p1y_ff);
               vz_in = 17'(nz) - 17'(p1z_ff);
            end
            default: begin
               px_in = nx;
               py_in = ny;
               pz_in = nz;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      p1x_ff   <= p1x_in;
      p1y_ff   <= p1y_in;
      p1z_ff   <= p1z_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
      ux_ff    <= ux_in;
      uy_ff    <= uy_in;
      uz_ff    <= uz_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      vz_ff    <= vz_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      nrm_ff   <= nrm_in;
      t2_ff    <= t2_in;
      lim_ff   <= lim_in;
      val_ff   <= val_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      first_ff <= first_in;
      sh_ff    <= sh_in;
      dst_ff   <= dst_in;
   end

   // The accumulator holds the squared plane value, which is never negative.
   assign less = $unsigned(acc_ff) < {12'b0, lim_ff};

endmodule

>>> rtl/ransac_plane_inlier_search.sv
// Plane inlier search: load transactions write points into the store, trial transactions fit
// a plane through three sample points and mark every point within the distance tolerance,
// and query transactions read one bit of the best inlier set. A single 32x32 multiplier with
// a 112-bit accumulator does all multiplications; each micro-op multiplies, then accumulates.
// A trial clears the candidate set, marks the samples, fits the plane, then skips each point
// already marked and evaluates each other point up to point_count; with duplicate samples it
// stops after marking. After reset the block clears the membership store before it accepts
// its first transaction. The user must write configuration with csr_write, csr_index and
// csr_wdata only while the block is idle; the block itself does not enforce this.
module ransac_plane_inlier_search #(
   parameter int MAX_POINTS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rpis_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rpis_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);
   import rpis_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int KW = $clog2(MAX_POINTS + 1);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CLEAR = 4'd2;
   localparam logic [3:0] S_MARK  = 4'd3;
   localparam logic [3:0] S_RD    = 4'd4;
   localparam logic [3:0] S_SETUP = 4'd5;
   localparam logic [3:0] S_WRD   = 4'd6;
   localparam logic [3:0] S_WCHK  = 4'd7;
   localparam logic [3:0] S_WOP   = 4'd8;
   localparam logic [3:0] S_WCMP  = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;
   localparam logic [3:0] S_QRY   = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;

   function automatic logic [AW-1:0] to_addr(logic [INDEX_W-1:0] i);
      logic [31:0] w;
      w = 32'(i);
      return w[AW-1:0];
   endfunction

   function automatic logic idx_ok(logic [INDEX_W-1:0] i);
      return 32'(i) < 32'(MAX_POINTS);
   endfunction

   logic [3:0]         state_ff, state_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [1:0]         j_ff, j_in;
   logic [5:0]         step_ff, step_in;
   logic               ph_ff, ph_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0] best_size_ff, best_size_in;
   logic               best_side_ff, best_side_in;
   logic [COUNT_W-1:0] point_count_ff, point_count_in;
   logic [15:0]        tol_ff, tol_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [INDEX_W-1:0] idx_ff, idx_in, s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic [COUNT_W-1:0] res_trial_ff, res_trial_in;
   logic               res_became_ff, res_became_in, res_inb_ff, res_inb_in;

   logic               accept;
   logic               cand;
   logic [31:0]        n_eff;
   logic               last_sweep;
   logic [COUNT_W-1:0] distinct_cnt;
   logic               out_free;

   mac_ctrl_type       mctrl;
   logic               less;
   logic               pt_we;
   logic [AW-1:0]      raddr, bm_waddr;
   bm_wr_type          bm_wr;
   logic               bm_we;
   logic [47:0]        pt_rdata;
   logic [1:0]         bm_rdata;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = state_ff != S_IDLE;
   assign cand       = ~best_side_ff;
   assign n_eff      = (32'(point_count_ff) < 32'(MAX_POINTS)) ? 32'(point_count_ff)
                                                               : 32'(MAX_POINTS);
   assign last_sweep = 32'(k_ff) == 32'(MAX_POINTS - 1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign distinct_cnt = COUNT_W'(1) + COUNT_W'(s2_ff != s1_ff)
                       + COUNT_W'((s3_ff != s1_ff) && (s3_ff != s2_ff));

   assign pt_we = accept && (req_data.mode == MODE_LOAD) && idx_ok(req_data.point_index);

   always_comb begin
      point_count_in = point_count_ff;
      tol_in         = tol_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_POINT_COUNT: point_count_in = csr_wdata[COUNT_W-1:0];
            REG_TOLERANCE:   tol_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      step_in       = step_ff;
      ph_in         = ph_ff;
      cnt_in        = cnt_ff;
      best_size_in  = best_size_ff;
      best_side_in  = best_side_ff;
      idx_in        = idx_ff;
      s1_in         = s1_ff;
      s2_in         = s2_ff;
      s3_in         = s3_ff;
      res_trial_in  = res_trial_ff;
      res_became_in = res_became_ff;
      res_inb_in    = res_inb_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      raddr         = k_ff[AW-1:0];
      bm_waddr      = k_ff[AW-1:0];
      bm_we         = 1'b0;
      bm_wr.data    = 1'b0;
      bm_wr.we0     = 1'b0;
      bm_wr.we1     = 1'b0;
      mctrl.mul_en  = 1'b0;
      mctrl.acc_en  = 1'b0;
      mctrl.uop     = ucode(step_ff);
      mctrl.pt_en   = 1'b0;
      mctrl.pt_sel  = PT_CUR;

      unique case (state_ff)
         S_INIT: begin
            bm_wr.we0 = 1'b1;
            bm_wr.we1 = 1'b1;
            if (last_sweep) begin
               state_in = S_IDLE;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         S_IDLE: begin
            raddr = to_addr(req_data.point_index);
            if (accept) begin
               idx_in        = req_data.point_index;
               s1_in         = req_data.sample_first;
               s2_in         = req_data.sample_second;
               s3_in         = req_data.sample_third;
               res_trial_in  = '0;
               res_became_in = 1'b0;
               res_inb_in    = 1'b0;
               k_in          = '0;
               priority if (req_data.mode == MODE_TRIAL && idx_ok(req_data.sample_first)
                            && idx_ok(req_data.sample_second)
                            && idx_ok(req_data.sample_third)) begin
                  state_in = S_CLEAR;
               end else if (req_data.mode == MODE_QUERY) begin
                  state_in = S_QRY;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_CLEAR: begin
            bm_we = 1'b1;
            if (last_sweep) begin
               j_in     = '0;
               state_in = S_MARK;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         S_MARK: begin
            bm_we      = 1'b1;
            bm_wr.data = 1'b1;
            unique case (j_ff)
               2'd0:    bm_waddr = to_addr(s1_ff);
               2'd1:    bm_waddr = to_addr(s2_ff);
               default: bm_waddr = to_addr(s3_ff);
            endcase
            if (j_ff == 2'd2) begin
               cnt_in = distinct_cnt;
               j_in   = '0;
               // Repeated samples give no plane: the candidate is just the distinct samples.
               state_in = (distinct_cnt == COUNT_W'(3)) ? S_RD : S_DONE;
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         S_RD: begin
            mctrl.pt_en = j_ff != 2'd0;
            unique case (j_ff)
               2'd0: begin
                  raddr = to_addr(s1_ff);
               end
               2'd1: begin
                  raddr        = to_addr(s2_ff);
                  mctrl.pt_sel = PT_P1;
               end
               2'd2: begin
                  raddr        = to_addr(s3_ff);
                  mctrl.pt_sel = PT_P2;
               end
               default: begin
                  mctrl.pt_sel = PT_P3;
               end
            endcase
            if (j_ff == 2'd3) begin
               step_in  = '0;
               ph_in    = 1'b0;
               state_in = S_SETUP;
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         S_SETUP: begin
            mctrl.mul_en = !ph_ff;
            mctrl.acc_en = ph_ff;
            ph_in        = !ph_ff;
            if (ph_ff) begin
               if (step_ff == STEP_SETUP_LAST) begin
                  k_in     = '0;
                  state_in = S_WRD;
               end else begin
                  step_in = step_ff + 6'd1;
               end
            end
         end
         S_WRD: begin
            if (32'(k_ff) < n_eff) begin
               state_in = S_WCHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WCHK: begin
            if (bm_rdata[cand]) begin
               k_in     = k_ff + KW'(1);
               state_in = S_WRD;
            end else begin
               mctrl.pt_en = 1'b1;
               step_in     = STEP_POINT_FIRST;
               ph_in       = 1'b0;
               state_in    = S_WOP;
            end
         end
         S_WOP: begin
            mctrl.mul_en = !ph_ff;
            mctrl.acc_en = ph_ff;
            ph_in        = !ph_ff;
            if (ph_ff) begin
               if (step_ff == STEP_POINT_LAST) begin
                  state_in = S_WCMP;
               end else begin
                  step_in = step_ff + 6'd1;
               end
            end
         end
         S_WCMP: begin
            if (less) begin
               bm_we      = 1'b1;
               bm_wr.data = 1'b1;
               if (cnt_ff < COUNT_MAX) begin
                  cnt_in = cnt_ff + COUNT_W'(1);
               end
            end
            k_in     = k_ff + KW'(1);
            state_in = S_WRD;
         end
         S_DONE: begin
            res_trial_in = cnt_ff;
            if (cnt_ff > best_size_ff) begin
               best_size_in  = cnt_ff;
               best_side_in  = cand;
               res_became_in = 1'b1;
            end
            state_in = S_FIN;
         end
         S_QRY: begin
            res_inb_in = idx_ok(idx_ff) ? bm_rdata[best_side_ff] : 1'b0;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.trial_count = res_trial_ff;
               rsp_data_in.became_best = res_became_ff;
               rsp_data_in.best_count  = best_size_ff;
               rsp_data_in.in_best     = res_inb_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (bm_we) begin
         bm_wr.we0 = !cand;
         bm_wr.we1 = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         k_ff           <= '0;
         best_size_ff   <= '0;
         best_side_ff   <= 1'b0;
         point_count_ff <= COUNT_W'(1);
         tol_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         k_ff           <= k_in;
         best_size_ff   <= best_size_in;
         best_side_ff   <= best_side_in;
         point_count_ff <= point_count_in;
         tol_ff         <= tol_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      step_ff       <= step_in;
      ph_ff         <= ph_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      s3_ff         <= s3_in;
      res_trial_ff  <= res_trial_in;
      res_became_ff <= res_became_in;
      res_inb_ff    <= res_inb_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rpis_store #(
      .MAX_POINTS(MAX_POINTS),
      .AW        (AW)
   ) u_store (
      .clock    (clock),
      .pt_we    (pt_we),
      .pt_waddr (to_addr(req_data.point_index)),
      .pt_wdata ({req_data.coord_x, req_data.coord_y, req_data.coord_z}),
      .bm_wr    (bm_wr),
      .bm_waddr (bm_waddr),
      .raddr    (raddr),
      .pt_rdata (pt_rdata),
      .bm_rdata (bm_rdata)
   );

   rpis_mac u_mac (
      .clock     (clock),
      .ctrl      (mctrl),
      .pt_data   (pt_rdata),
      .tolerance (tol_ff),
      .less      (less)
   );

endmodule

>>> bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rpis_pkg::*;

   typedef struct {
      bit      known;
      req_type item;
      rsp_type want;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write;
   logic        csr_index;
   logic [15:0] csr_wdata;

   ransac_plane_inlier_search dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the point store and the two membership banks.
   logic signed [15:0] pt_x [4096];
   logic signed [15:0] pt_y [4096];
   logic signed [15:0] pt_z [4096];
   bit [1:0]           member [4096];
   bit                 best_bank;
   int unsigned        best_total;
   int unsigned        cfg_points;
   bit [15:0]          cfg_tol;
   bit                 loaded [4096];
   int                 loaded_list [$];

   rsp_type      pending_results [$];
   plan_row_type plan [$];
   int           errors;
   bit           calm;
   int           plane_ka, plane_kb, plane_kc;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #60ms;
      $display("FAILURE");
      $finish;
   end

   function automatic bit [127:0] squared(longint v);
      bit [63:0] m;
      m = (v < 0) ? 64'(-v) : 64'(v);
      return {64'd0, m} * {64'd0, m};
   endfunction

   function automatic int unsigned inlier_count(int s1, int s2, int s3);
      bit          cand;
      int unsigned cnt, n;
      int          samp [3];
      longint      ux, uy, uz, vx, vy, vz, a, b, c, d, val;
      bit [127:0]  t2, lim;
      cand = ~best_bank;
      cnt = 0;
      samp = '{s1, s2, s3};
      for (int k = 0; k < 4096; k++) member[k][cand] = 1'b0;
      foreach (samp[i]) begin
         if (!member[samp[i]][cand]) begin
            member[samp[i]][cand] = 1'b1;
            cnt++;
         end
      end
      if (cnt == 3) begin
         ux = longint'(pt_x[s2]) - longint'(pt_x[s1]);
         uy = longint'(pt_y[s2]) - longint'(pt_y[s1]);
         uz = longint'(pt_z[s2]) - longint'(pt_z[s1]);
         vx = longint'(pt_x[s3]) - longint'(pt_x[s1]);
         vy = longint'(pt_y[s3]) - longint'(pt_y[s1]);
         vz = longint'(pt_z[s3]) - longint'(pt_z[s1]);
         a = uy * vz - uz * vy;
         b = uz * vx - ux * vz;
         c = ux * vy - uy * vx;
         d = -(a * longint'(pt_x[s1]) + b * longint'(pt_y[s1]) + c * longint'(pt_z[s1]));
         t2 = {112'd0, cfg_tol} * {112'd0, cfg_tol};
         lim = (squared(a) + squared(b) + squared(c)) * t2;
         n = (cfg_points < 4096) ? cfg_points : 4096;
         for (int k = 0; k < n; k++) begin
            if (member[k][cand]) continue;
            val = a * longint'(pt_x[k]) + b * longint'(pt_y[k]) + c * longint'(pt_z[k]) + d;
            if (squared(val) < lim) begin
               member[k][cand] = 1'b1;
               if (cnt < COUNT_MAX) cnt++;
            end
         end
      end
      return cnt;
   endfunction

   function automatic rsp_type plane_search_step(req_type r);
      rsp_type     o;
      int unsigned cnt;
      o = '0;
      case (r.mode)
         MODE_LOAD: begin
            pt_x[r.point_index] = r.coord_x;
            pt_y[r.point_index] = r.coord_y;
            pt_z[r.point_index] = r.coord_z;
            if (!loaded[r.point_index]) begin
               loaded[r.point_index] = 1'b1;
               loaded_list.push_back(int'(r.point_index));
            end
         end
         MODE_TRIAL: begin
            cnt = inlier_count(int'(r.sample_first), int'(r.sample_second),
                               int'(r.sample_third));
            o.trial_count = 13'(cnt);
            if (cnt > best_total) begin
               best_total = cnt;
               best_bank = ~best_bank;
               o.became_best = 1'b1;
            end
         end
         MODE_QUERY: o.in_best = member[r.point_index][best_bank];
         default: ;
      endcase
      o.best_count = 13'(best_total);
      return o;
   endfunction

   function automatic req_type load_item(int idx, int x, int y, int z);
      req_type r;
      r = '0;
      r.mode = MODE_LOAD;
      r.point_index = 12'(idx);
      r.coord_x = 16'(x);
      r.coord_y = 16'(y);
      r.coord_z = 16'(z);
      return r;
   endfunction

   function automatic req_type trial_item(int s1, int s2, int s3);
      req_type r;
      r = '0;
      r.mode = MODE_TRIAL;
      r.sample_first = 12'(s1);
      r.sample_second = 12'(s2);
      r.sample_third = 12'(s3);
      return r;
   endfunction

   function automatic req_type query_item(int idx);
      req_type r;
      r = '0;
      r.mode = MODE_QUERY;
      r.point_index = 12'(idx);
      return r;
   endfunction

   function automatic req_type noise_item();
      req_type      r;
      logic [127:0] w;
      w = {$urandom, $urandom, $urandom, $urandom};
      r = w[$bits(req_type)-1:0];
      r.mode = 2'b11;
      return r;
   endfunction

   // Most points sit on the current plane, some are nudged off it, a few are anywhere.
   function automatic req_type plane_point(int idx);
      int x, y, z;
      if ($urandom_range(0, 5) == 0)
         return load_item(idx, $urandom, $urandom, $urandom);
      x = ($urandom_range(0, 40) - 20) * 256;
      y = ($urandom_range(0, 40) - 20) * 256;
      z = plane_ka * x + plane_kb * y + plane_kc * 256;
      if ($urandom_range(0, 3) == 0) z += $urandom_range(0, 600) - 300;
      return load_item(idx, x, y, z);
   endfunction

   function automatic int pick_loaded();
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic plan_row_type row(bit known, req_type item, rsp_type want = '0);
      plan_row_type p;
      p.known = known;
      p.item = item;
      p.want = want;
      return p;
   endfunction

   task automatic send(req_type r, bit known = 1'b0, rsp_type want = '0);
      int      g;
      rsp_type p;
      g = draw_wait();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      p = plane_search_step(r);
      pending_results.push_back(known ? want : p);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == REG_POINT_COUNT) cfg_points = 32'(value[12:0]);
      else cfg_tol = value;
   endtask

   task automatic run_phase(logic [15:0] points, logic [15:0] tol, int items, bit fast_fill);
      int n, pick, s1, s2, s3;
      drain();
      write_reg(REG_POINT_COUNT, points);
      write_reg(REG_TOLERANCE, tol);
      plane_ka = $urandom_range(0, 2) - 1;
      plane_kb = $urandom_range(0, 2) - 1;
      plane_kc = $urandom_range(0, 20) - 10;
      n = (cfg_points < 4096) ? cfg_points : 4096;
      // Every point that takes part in a trial has to be loaded first.
      calm = fast_fill;
      for (int k = 0; k < n; k++)
         if (!loaded[k]) send(plane_point(k));
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < items; i++) begin
         if (i == items / 2 && $urandom_range(0, 1) == 1) drain();
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            s1 = pick_loaded();
            s2 = pick_loaded();
            s3 = pick_loaded();
            if ($urandom_range(0, 9) == 0) s2 = s1;
            else if ($urandom_range(0, 9) == 0) s3 = s2;
            send(trial_item(s1, s2, s3));
         end else if (pick < 70) begin
            send(plane_point(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                           : $urandom_range(0, 63)));
         end else if (pick < 92) begin
            send(query_item(($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                                         : $urandom_range(0, 63)));
         end else begin
            send(noise_item());
         end
      end
   endtask

   // Result side: random stall, then compare against the oldest expectation.
   initial begin
      int      n;
      rsp_type want;
      rsp_stall = 1'b0;
      forever begin
         n = draw_wait();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_results.size() == 0) begin
            $display("%t unexpected result %p", $realtime, rsp_data);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.trial_count !== want.trial_count) begin
               $display("%t trial_count expected %0d got %0d", $realtime,
                        want.trial_count, rsp_data.trial_count);
               errors++;
            end
            if (rsp_data.became_best !== want.became_best) begin
               $display("%t became_best expected %0d got %0d", $realtime,
                        want.became_best, rsp_data.became_best);
               errors++;
            end
            if (rsp_data.best_count !== want.best_count) begin
               $display("%t best_count expected %0d got %0d", $realtime,
                        want.best_count, rsp_data.best_count);
               errors++;
            end
            if (rsp_data.in_best !== want.in_best) begin
               $display("%t in_best expected %0d got %0d", $realtime,
                        want.in_best, rsp_data.in_best);
               errors++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      errors = 0;
      calm = 1'b0;
      best_bank = 1'b0;
      best_total = 0;
      cfg_points = 1;
      cfg_tol = '0;

      // Rows run with the reset configuration: one point taking part, zero tolerance.
      plan.push_back(row(1, query_item(0), rsp_type'{13'd0, 1'b0, 13'd0, 1'b0}));
      plan.push_back(row(1, load_item(0, -32768, 32767, 0), '0));
      plan.push_back(row(1, load_item(4095, 32767, -32768, -1), '0));
      plan.push_back(row(1, load_item(1, 0, 0, 0), '0));
      plan.push_back(row(1, load_item(2, 256, 0, 0), '0));
      plan.push_back(row(1, load_item(3, 512, 0, 0), '0));
      plan.push_back(row(1, load_item(4, 0, 256, 0), '0));
      plan.push_back(row(1, {2'b11, {96{1'b1}}}, '0));
      // All three samples the same point.
      plan.push_back(row(1, trial_item(1, 1, 1), rsp_type'{13'd1, 1'b1, 13'd1, 1'b0}));
      plan.push_back(row(1, query_item(1), rsp_type'{13'd0, 1'b0, 13'd1, 1'b1}));
      // Three collinear points give a degenerate plane.
      plan.push_back(row(1, trial_item(1, 2, 3), rsp_type'{13'd3, 1'b1, 13'd3, 1'b0}));
      // With zero tolerance even an exact point on the plane is rejected.
      plan.push_back(row(1, trial_item(1, 2, 4), rsp_type'{13'd3, 1'b0, 13'd3, 1'b0}));
      plan.push_back(row(0, trial_item(4095, 0, 2)));
      plan.push_back(row(0, trial_item(2, 2, 4)));
      plan.push_back(row(0, query_item(4095)));
      plan.push_back(row(0, query_item(2048)));
      plan.push_back(row(0, query_item(0)));
      plan.push_back(row(0, {2'b11, {96{1'b0}}}));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send(plan[i].item, plan[i].known, plan[i].want);

      run_phase(16'd8, 16'd0, 18, 1'b0);
      run_phase(16'd16, 16'hFFFF, 18, 1'b0);
      run_phase(16'd40, 16'h0040, 18, 1'b0);
      run_phase(16'd48, 16'($urandom), 18, 1'b1);
      run_phase(16'd1, 16'h0180, 14, 1'b0);

      drain();
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
